// ===== sv/aes_block_encrypt_defines.svh =====
// ----------------------------------------------------------------------------
// AES block encryption assertion macros
// Shared concurrent assertion helpers for the cipher pipeline.
// ----------------------------------------------------------------------------
`ifndef AES_BLOCK_ENCRYPT_DEFINES_SVH
`define AES_BLOCK_ENCRYPT_DEFINES_SVH
`ifndef ASSERT_OFF
`define AES_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define AES_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define AES_ASSERT_IMP(label, clk, rst, a, b)
`define AES_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== sv/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// AES package
// Round count limits, the S-box and the round transforms.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int MaxRounds = 14;
  localparam int KeySlots  = 2 * (MaxRounds + 1);
  localparam int Stages    = MaxRounds + 1;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ENCRYPT = 1'b1
  } op_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte k of the state sits at [127-8k -: 8]
  function automatic logic [127:0] sub_shift(input logic [127:0] st);
    logic [127:0] t;
    int src;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = 4 * ((c + r) % 4) + r;
        t[127 - 8 * (4 * c + r) -: 8] = SBOX[st[127 - 8 * src -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] st);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = st[127 - 32 * c -: 8];
      a1 = st[119 - 32 * c -: 8];
      a2 = st[111 - 32 * c -: 8];
      a3 = st[103 - 32 * c -: 8];
      d0 = xtime(a0);
      d1 = xtime(a1);
      d2 = xtime(a2);
      d3 = xtime(a3);
      t[127 - 32 * c -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
      t[119 - 32 * c -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
      t[111 - 32 * c -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
      t[103 - 32 * c -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
    end
    mix_cols = t;
  endfunction

endpackage

// ===== sv/aes_stage.sv =====
// ----------------------------------------------------------------------------
// AES pipeline stage
// One cipher round, or the initial key addition at stage 0, with its own
// register; passes the block through unchanged once the block's round count is used up.
// ----------------------------------------------------------------------------
module aes_stage (
  input  logic         clk,
  input  logic         rst,
  input  logic [3:0]   stage_idx,
  input  logic [127:0] round_key,
  input  logic         up_valid,
  output logic         up_ready,
  input  logic [127:0] up_state,
  input  logic [3:0]   up_rounds,
  output logic         dn_valid,
  input  logic         dn_ready,
  output logic [127:0] dn_state,
  output logic [3:0]   dn_rounds
);

  logic [127:0] shifted;
  logic [127:0] mixed;
  logic [127:0] state_next;

  always_comb begin
    shifted = aes_pkg::sub_shift(up_state);
    mixed   = (stage_idx < up_rounds) ? aes_pkg::mix_cols(shifted) : shifted;
    priority if (stage_idx == 4'd0) begin
      state_next = up_state ^ round_key;
    end else if (stage_idx <= up_rounds) begin
      state_next = mixed ^ round_key;
    end else begin
      state_next = up_state;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_state  <= state_next;
      dn_rounds <= up_rounds;
    end
  end

endmodule

// ===== sv/aes_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// AES block encryption
// Fifteen-stage cipher pipeline over a pre-expanded round key store.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the opcode; tdata carries key_slot, data_hi and
// data_lo. A load request writes one 64-bit key half (data_hi) into slot
// key_slot at once if key_slot is below 30, and returns nothing. An encrypt
// request enters the pipeline and returns one ciphertext block on the output
// stream. For any round count, an encrypt request passes through every stage:
// the initial key addition and each of 14 round stages have one register each,
// and stages past the round count pass the block through.
// Throughput: one encrypt request per cycle while the receiver takes blocks. A
// load waits until no encrypt is in flight, so the key store never changes under
// a block. The output stage is a register; when the receiver stalls, bubbles
// close up and the pipeline keeps taking requests until every stage holds a block.
// Reset clears all valid bits and sets the round count to 10; the key store
// holds nothing defined until it is loaded.
// num_rounds lies at address 0 on the register port; 0 acts as 1, values
// above 14 act as 14.
// ----------------------------------------------------------------------------
`include "aes_block_encrypt_defines.svh"

module aes_block_encrypt (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [135:0]  s_tdata,   // key_slot[4:0], data_hi[68:5], data_lo[132:69], zero fill
  input  logic          s_tuser,   // opcode
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [127:0]  m_tdata,   // cipher_hi[63:0], cipher_lo[127:64]
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int Stages = aes_pkg::Stages;

  logic [3:0]   num_rounds;
  logic [63:0]  key_store [aes_pkg::KeySlots];
  logic [3:0]   rounds_clamped;
  logic         busy;
  logic         is_load;
  logic         accept;

  logic [Stages:0]  valid;
  logic [Stages:0]  ready;
  logic [127:0]     state  [Stages+1];
  logic [3:0]       rounds [Stages+1];

  logic [4:0]   key_slot;
  logic [63:0]  data_hi;
  logic [63:0]  data_lo;

  assign key_slot = s_tdata[4:0];
  assign data_hi  = s_tdata[68:5];
  assign data_lo  = s_tdata[132:69];
  assign is_load  = (s_tuser == aes_pkg::OP_LOAD);
  assign busy     = |valid[Stages:1];

  // hold a load until the pipeline drains
  assign s_tready = is_load ? !busy : ready[0];
  assign accept   = s_tvalid && s_tready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {28'd0, num_rounds} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rounds <= 4'd10;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      num_rounds <= pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_load && key_slot < 5'(aes_pkg::KeySlots)) begin
      key_store[key_slot] <= data_hi;
    end
  end

  always_comb begin
    priority if (num_rounds == 4'd0) begin
      rounds_clamped = 4'd1;
    end else if (num_rounds > 4'(aes_pkg::MaxRounds)) begin
      rounds_clamped = 4'(aes_pkg::MaxRounds);
    end else begin
      rounds_clamped = num_rounds;
    end
  end

  assign valid[0]  = s_tvalid && !is_load;
  assign state[0]  = {data_hi, data_lo};
  assign rounds[0] = rounds_clamped;

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    aes_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .stage_idx (4'(g)),
      .round_key ({key_store[2 * g], key_store[2 * g + 1]}),
      .up_valid  (valid[g]),
      .up_ready  (ready[g]),
      .up_state  (state[g]),
      .up_rounds (rounds[g]),
      .dn_valid  (valid[g+1]),
      .dn_ready  (ready[g+1]),
      .dn_state  (state[g+1]),
      .dn_rounds (rounds[g+1])
    );
  end

  assign ready[Stages] = m_tready;
  assign m_tvalid      = valid[Stages];
  assign m_tdata       = {state[Stages][63:0], state[Stages][127:64]};

  `AES_ASSERT_IMP(a_load_idle, clk, rst, accept && is_load, !busy)
  `AES_ASSERT_NEXT(a_enc_enters, clk, rst, accept && !is_load, valid[1])
  `AES_ASSERT_IMP(a_rounds_range, clk, rst, valid[1],
                  rounds[1] != 4'd0 && rounds[1] <= 4'(aes_pkg::MaxRounds))

endmodule

// ===== dv/aes_block_encrypt_checker.sv =====
// ----------------------------------------------------------------------------
// AES block encryption checker
// Tracks key loads and the round count, predicts each ciphertext block from
// accepted encrypt requests, and compares it with the output stream in order.
// ----------------------------------------------------------------------------
module aes_block_encrypt_checker
  import aes_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [135:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [127:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending,
  output int           blocks_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSlots = 30;
  localparam int RoundLimit = 14;
  localparam logic [2:0] AddrRounds = 3'd0;

  logic [63:0]  key_halves [NumSlots];
  logic [3:0]   round_cfg;
  logic [127:0] cipher_fifo [$];

  function automatic logic [7:0] gf_x2(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] round_key(int r);
    return {key_halves[(2 * r) % NumSlots], key_halves[(2 * r + 1) % NumSlots]};
  endfunction

  function automatic logic [127:0] encrypt_block(logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    logic [127:0] st;
    int rounds;
    rounds = (round_cfg == 0) ? 1 : (round_cfg > RoundLimit) ? RoundLimit : round_cfg;
    st = blk ^ round_key(0);
    for (int r = 1; r <= rounds; r++) begin
      for (int k = 0; k < 16; k++) s[k] = st[127 - 8 * k -: 8];
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++) t[4 * c + q] = SBOX[s[4 * ((c + q) % 4) + q]];
      if (r < rounds) begin
        for (int c = 0; c < 16; c += 4) begin
          a0 = t[c]; a1 = t[c + 1]; a2 = t[c + 2]; a3 = t[c + 3];
          t[c]     = gf_x2(a0) ^ gf_x2(a1) ^ a1 ^ a2 ^ a3;
          t[c + 1] = a0 ^ gf_x2(a1) ^ gf_x2(a2) ^ a2 ^ a3;
          t[c + 2] = a0 ^ a1 ^ gf_x2(a2) ^ gf_x2(a3) ^ a3;
          t[c + 3] = gf_x2(a0) ^ a0 ^ a1 ^ a2 ^ gf_x2(a3);
        end
      end
      for (int k = 0; k < 16; k++) st[127 - 8 * k -: 8] = t[k];
      st = st ^ round_key(r);
    end
    return st;
  endfunction

  always_ff @(posedge clk) begin
    logic [127:0] exp_c;
    logic [127:0] got_c;
    if (rst) begin
      round_cfg <= 4'd10;
      fail_count <= 0;
      blocks_seen <= 0;
      cipher_fifo.delete();
      for (int i = 0; i < NumSlots; i++) key_halves[i] <= '0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == AddrRounds)
        round_cfg <= pwdata[3:0];
      if (s_tvalid && s_tready) begin
        if (op_t'(s_tuser) == OP_LOAD) begin
          if (s_tdata[4:0] < NumSlots) key_halves[s_tdata[4:0]] <= s_tdata[68:5];
        end else begin
          cipher_fifo.push_back(encrypt_block({s_tdata[68:5], s_tdata[132:69]}));
        end
      end
      if (m_tvalid && m_tready) begin
        blocks_seen <= blocks_seen + 1;
        got_c = {m_tdata[63:0], m_tdata[127:64]};
        if (cipher_fifo.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("ERROR: unexpected block %h", got_c);
        end else begin
          exp_c = cipher_fifo.pop_front();
          if (exp_c[127:64] !== got_c[127:64] || exp_c[63:0] !== got_c[63:0]) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("ERROR: cipher hi/lo exp %h %h got %h %h", exp_c[127:64],
                       exp_c[63:0], got_c[127:64], got_c[63:0]);
          end
        end
      end
    end
  end

  assign pending = cipher_fifo.size();
endmodule

// ===== dv/tb_aes_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// AES block encryption testbench
// Loads key schedules, encrypts directed and random blocks under several round
// counts with bursty input and a stalling receiver, and reports the verdict.
// ----------------------------------------------------------------------------
module tb_aes_block_encrypt;
  import aes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSlots = 30;
  localparam logic [2:0] AddrRounds = 3'd0;
  localparam int Latency = 20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0, s_tready, s_tuser = 1'b0;
  logic [135:0] s_tdata = '0;
  logic m_tvalid, m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  int fail_count, pending, blocks_seen;
  int requests_sent = 0;
  bit long_hold = 1'b0;
  bit stim_done = 1'b0;
  int gap_left = 0;
  int burst_left = 0;

  always #4 clk = ~clk;

  aes_block_encrypt dut (.*);

  aes_block_encrypt_checker chk (.*);

  // receiver: own stall pattern, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst || long_hold) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_request(op_t op, logic [4:0] slot, logic [63:0] hi, logic [63:0] lo);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    while (gap_left > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      gap_left--;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {3'b000, lo, hi, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    requests_sent++;
  endtask

  task automatic go_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_rounds(logic [3:0] n);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= AddrRounds; pwdata <= {28'd0, n};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic load_schedule(bit all_ones);
    for (int i = 0; i < NumSlots; i++)
      send_request(OP_LOAD, 5'(i), all_ones ? '1 : {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  task automatic random_phase(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 19);
      if (k == 0)
        send_request(OP_LOAD, 5'($urandom_range(0, 31)), {$urandom, $urandom},
                     {$urandom, $urandom});
      else
        send_request(OP_ENCRYPT, 5'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
    end
  endtask

  initial begin
    int rounds_list [6];
    rounds_list = '{4'd1, 4'd12, 4'd14, 4'd0, 4'd15, 4'd10};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: default round count, extreme keys and blocks
    load_schedule(1'b1);
    send_request(OP_ENCRYPT, 5'd0, '0, '0);
    send_request(OP_ENCRYPT, 5'd31, '1, '1);
    load_schedule(1'b0);
    send_request(OP_ENCRYPT, 5'd7, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_request(OP_LOAD, 5'd30, '1, '1);
    send_request(OP_LOAD, 5'd31, '0, '0);
    send_request(OP_ENCRYPT, 5'd0, 64'h8000000000000001, 64'h0123456789abcdef);
    // fill the pipeline while the receiver holds off
    @(negedge clk);
    long_hold <= 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        @(negedge clk);
        long_hold <= 1'b0;
      end
      random_phase(40);
    join
    go_idle();
    foreach (rounds_list[i]) begin
      write_rounds(rounds_list[i]);
      if (i % 2 == 0) load_schedule(1'b0);
      random_phase(110);
      go_idle();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done && pending == 0);
    repeat (Latency * 2) @(posedge clk);
    $display("Covered %0d requests and %0d cipher blocks over round counts 0..15.",
             requests_sent, blocks_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/aes_pkg.sv
sv/aes_stage.sv
sv/aes_block_encrypt.sv
dv/aes_block_encrypt_checker.sv
dv/tb_aes_block_encrypt.sv
